@@ sv/cpd_pkg.sv @@
// Shared constants, types and state codes for the closest pair distance block.
package cpd_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int COORD_W    = 24;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int LIMIT_W    = 16;
	localparam int FRAC_W     = 8;
	localparam int LIM_EXT_W  = LIMIT_W + FRAC_W;
	localparam int LIM_SQ_W   = 2 * LIM_EXT_W;
	localparam int DIST_W     = 24;
	localparam int ROOT_W     = SQ_W + 2;
	localparam int ROOT_STEPS = ROOT_W / 2;
	localparam int STEP_W     = $clog2(ROOT_STEPS);
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10000);
	localparam logic                LIMIT_IDX   = 1'b0;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      last;
		logic                      store;
	} cmd_t;

	typedef struct packed {
		logic [DIST_W-1:0] min_distance;
		logic              is_infinite;
		logic              points_dropped;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_I,
		ST_WAIT_I,
		ST_PAIR,
		ST_DRAIN,
		ST_CHECK,
		ST_ROOT,
		ST_EMIT
	} back_state_t;

endpackage

@@ sv/closest_pair_distance.sv @@
// Top level of the closest pair distance block: register port, queue, result register.
//
//  channel | handshake                  | word
//  --------+----------------------------+--------------------------------------------
//  in      | in_valid / in_stall        | point_x, point_y, last_point
//  out     | out_valid / out_stall      | min_distance, is_infinite, points_dropped
//  cfg     | psel/penable/pwrite/pready | paddr, pwdata, prdata (distance_limit)
//
// Flow: the front takes one word a cycle into a four-entry queue unless it is
// full; the back stores one point a cycle while the queue holds words. After
// the last point of n the back runs the pair search through the single store
// read port, drains the pipeline, checks the limit, runs the one-bit-per-cycle
// square root (skipped when the result is infinite) and hands the result on.
// Reset: control state clears at once; the point store needs no clearing pass.
// Stalls: in_stall rises only when the queue is full; out_stall holds the result
// register, and the back waits on it only when it has a fresh result to hand over.
module closest_pair_distance (
	input  logic                  clk,
	input  logic                  arst_n,
	// point words
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [23:0]    point_x,
	input  logic signed [23:0]    point_y,
	input  logic                  last_point,
	// result words
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [23:0]           min_distance,
	output logic                  is_infinite,
	output logic                  points_dropped,
	// register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import cpd_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic               cfg_wr;
	logic               sel_limit;

	logic               push;
	cmd_t               push_cmd;
	cmd_t               head_cmd;
	logic               q_full;
	logic               q_empty;
	logic               pop;

	logic               emit;
	logic               out_free;
	res_t               back_res;
	res_t               res_q;
	logic               out_valid_q;

	// registers sit at 4*i; the low byte-lane bits are ignored
	assign pready    = 1'b1;
	assign sel_limit = (paddr[PADDR_W-1] == LIMIT_IDX);
	assign cfg_wr    = psel & penable & pwrite & pready & sel_limit;
	assign prdata    = sel_limit ? PDATA_W'(limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	cpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.point_x   (point_x),
		.point_y   (point_y),
		.last_point(last_point),
		.q_full    (q_full),
		.in_stall  (in_stall),
		.push      (push),
		.cmd       (push_cmd)
	);

	cpd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head_cmd(head_cmd),
		.full    (q_full),
		.empty   (q_empty)
	);

	// result register frees when empty or when its word leaves this cycle
	assign out_free = ~out_valid_q | ~out_stall;

	cpd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.head_cmd      (head_cmd),
		.pop           (pop),
		.distance_limit(limit_q),
		.out_free      (out_free),
		.emit          (emit),
		.result        (back_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= back_res;
		end
	end

	assign out_valid      = out_valid_q;
	assign min_distance   = res_q.min_distance;
	assign is_infinite    = res_q.is_infinite;
	assign points_dropped = res_q.points_dropped;

endmodule

@@ sv/cpd_front.sv @@
// Front end: takes point words, tracks set fill and tags each word store or drop.
module cpd_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic signed [23:0]           point_x,
	input  logic signed [23:0]           point_y,
	input  logic                         last_point,
	input  logic                         q_full,
	output logic                         in_stall,
	output logic                         push,
	output cpd_pkg::cmd_t                cmd
);
	import cpd_pkg::*;

	logic [CNT_W-1:0] fill_q;

	assign in_stall = q_full;
	assign push     = in_valid & ~q_full;

	always_comb begin
		cmd.x     = point_x;
		cmd.y     = point_y;
		cmd.last  = last_point;
		cmd.store = (fill_q != CNT_W'(MAX_POINTS));
	end

	// count of the set seen so far; saturates at the store depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (push) begin
			if (last_point) begin
				fill_q <= '0;
			end else if (cmd.store) begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

endmodule

@@ sv/cpd_queue.sv @@
// Short command queue between the front end and the search engine.
module cpd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cpd_pkg::cmd_t push_cmd,
	input  logic          pop,
	output cpd_pkg::cmd_t head_cmd,
	output logic          full,
	output logic          empty
);
	import cpd_pkg::*;

	cmd_t               entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   level_q;

	assign full     = (level_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign empty    = (level_q == '0);
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + (Q_PTR_W+1)'(1);
				2'b01:   level_q <= level_q - (Q_PTR_W+1)'(1);
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

@@ sv/cpd_sqrt.sv @@
// Iterative floor square root, one result bit per cycle.
module cpd_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cpd_pkg::SQ_W-1:0]      value,
	output logic                          done,
	output logic [cpd_pkg::DIST_W-1:0]    root
);
	import cpd_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [ROOT_W-1:0] rem_q;
	logic [ROOT_W-1:0] res_q;
	logic [ROOT_W-1:0] bit_q;
	logic [ROOT_W-1:0] trial;

	assign trial = res_q + bit_q;
	assign done  = done_q;
	assign root  = res_q[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(ROOT_STEPS - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= ROOT_W'(value);
			res_q <= '0;
			bit_q <= ROOT_W'(1) << (ROOT_W - 2);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

@@ sv/cpd_back.sv @@
// Back end: point store, all-pairs squared distance search, limit check and root.
module cpd_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  cpd_pkg::cmd_t                  head_cmd,
	output logic                           pop,
	input  logic [cpd_pkg::LIMIT_W-1:0]    distance_limit,
	input  logic                           out_free,
	output logic                           emit,
	output cpd_pkg::res_t                  result
);
	import cpd_pkg::*;

	localparam int WORD_W = 2 * COORD_W;

	back_state_t state_q, state_d;

	logic [WORD_W-1:0] mem [MAX_POINTS];
	logic [WORD_W-1:0] rd_q;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              mem_we;

	logic [CNT_W-1:0]  wptr_q;
	logic              ovf_q;
	logic [ADDR_W-1:0] i_q;
	logic [ADDR_W-1:0] j_q;
	logic [ADDR_W-1:0] last_idx;
	logic signed [COORD_W-1:0] pix_q;
	logic signed [COORD_W-1:0] piy_q;
	logic [SQ_W-1:0]   best_q;
	logic [LIM_SQ_W-1:0] lim_sq_q;
	logic [LIM_EXT_W-1:0] lim_ext;

	logic              v_s1, v_s2, v_s3;
	logic signed [DIFF_W-1:0] dx_s2, dy_s2;
	logic [DIFF_W-1:0] magx, magy;
	logic [SQ_W-1:0]   sqx_s3, sqy_s3;
	logic [SQ_W-1:0]   sum_c;
	logic signed [COORD_W-1:0] pjx, pjy;

	logic [CNT_W-1:0]  n_new;
	logic              too_few;
	logic              sq_start;
	logic              sq_done;
	logic [DIST_W-1:0] sq_root;
	logic              inf_q;
	logic [DIST_W-1:0] dist_q;

	assign last_idx = ADDR_W'(wptr_q - CNT_W'(1));
	assign n_new    = wptr_q + CNT_W'(head_cmd.store);
	assign too_few  = (n_new < CNT_W'(2));
	assign lim_ext  = {distance_limit, {FRAC_W{1'b0}}};

	assign pjx = rd_q[WORD_W-1:COORD_W];
	assign pjy = rd_q[COORD_W-1:0];

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		mem_we   = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = i_q;
		sq_start = 1'b0;
		emit     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					pop    = 1'b1;
					mem_we = head_cmd.store;
					if (head_cmd.last) begin
						state_d = too_few ? ST_EMIT : ST_RD_I;
					end
				end
			end
			ST_RD_I: begin
				rd_en   = 1'b1;
				state_d = ST_WAIT_I;
			end
			ST_WAIT_I: begin
				state_d = ST_PAIR;
			end
			ST_PAIR: begin
				rd_en   = 1'b1;
				rd_addr = j_q;
				if (j_q == last_idx) begin
					state_d = ((i_q + ADDR_W'(1)) == last_idx) ? ST_DRAIN : ST_RD_I;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2 && !v_s3) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (best_q >= SQ_W'(lim_sq_q)) begin
					state_d = ST_EMIT;
				end else begin
					sq_start = 1'b1;
					state_d  = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (sq_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// point store: written while loading, read at most one word a cycle while searching
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wptr_q[ADDR_W-1:0]] <= {head_cmd.x, head_cmd.y};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			ovf_q  <= 1'b0;
			best_q <= '1;
			inf_q  <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_PAIR);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3 && (sum_c < best_q)) begin
				best_q <= sum_c;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						wptr_q <= n_new;
						ovf_q  <= ovf_q | ~head_cmd.store;
						inf_q  <= too_few;
					end
				end
				ST_CHECK: inf_q <= (best_q >= SQ_W'(lim_sq_q));
				ST_EMIT: begin
					if (out_free) begin
						wptr_q <= '0;
						ovf_q  <= 1'b0;
						best_q <= '1;
					end
				end
				default: ;
			endcase
		end
	end

	// pair pipeline: read, difference, squares, sum and running minimum
	always_ff @(posedge clk) begin
		lim_sq_q <= lim_ext * lim_ext;
		dx_s2    <= DIFF_W'(pix_q) - DIFF_W'(pjx);
		dy_s2    <= DIFF_W'(piy_q) - DIFF_W'(pjy);
		sqx_s3   <= magx * magx;
		sqy_s3   <= magy * magy;
		case (state_q)
			ST_IDLE: begin
				if (pop && head_cmd.last) begin
					i_q    <= '0;
					dist_q <= '0;
				end
			end
			ST_WAIT_I: begin
				pix_q <= pjx;
				piy_q <= pjy;
				j_q   <= i_q + ADDR_W'(1);
			end
			ST_PAIR: begin
				if (j_q == last_idx) begin
					i_q <= i_q + ADDR_W'(1);
				end else begin
					j_q <= j_q + ADDR_W'(1);
				end
			end
			ST_CHECK: dist_q <= '0;
			ST_ROOT: begin
				if (sq_done) begin
					dist_q <= sq_root;
				end
			end
			default: ;
		endcase
	end

	assign magx  = dx_s2[DIFF_W-1] ? DIFF_W'(-dx_s2) : DIFF_W'(dx_s2);
	assign magy  = dy_s2[DIFF_W-1] ? DIFF_W'(-dy_s2) : DIFF_W'(dy_s2);
	assign sum_c = sqx_s3 + sqy_s3;

	always_comb begin
		result.min_distance   = dist_q;
		result.is_infinite    = inf_q;
		result.points_dropped = ovf_q;
	end

	cpd_sqrt u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.value (best_q),
		.done  (sq_done),
		.root  (sq_root)
	);

endmodule
